>>> rtl/sorted_leaf_table_macros.svh
// Assertion macros used by the sorted leaf table RTL.
`ifndef SORTED_LEAF_TABLE_MACROS_SVH
`define SORTED_LEAF_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted_leaf_table: check failed");
// next-cycle implication
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted_leaf_table: check failed");
`else
`define SLT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/slt_pkg.sv
// Shared types and constants of the sorted leaf table.
package slt_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 6;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;
	localparam int LINK_W   = 32;
	localparam int ENTRY_W  = KEY_W + VAL_W;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_SPLIT  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUP       = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

>>> rtl/sorted_leaf_table.sv
// Top level of the sorted leaf table: sequencer, entry memory and key comparator.
// One B+ tree leaf held as a key-sorted array of up to 32 key/record-id pairs. One request
// is worked on at a time; req_stall is high from the transfer until the request has been
// fully handled. All entry accesses go through one memory with one read and one write port
// and a registered read, and every key test uses one comparator. A lookup is a binary
// search: each step reads the middle entry (S_SEARCH) and narrows the bounds (S_CMP), and
// a final read fetches the match candidate. An insert shifts larger entries up, then
// writes the pair and loads its result; a split reads and emits each upper-half entry.
// Each result is one rsp transfer; last marks the final one of a request. A finished
// result waits in the output register while the next request may already be taken.
`include "sorted_leaf_table_macros.svh"

module sorted_leaf_table (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          kind,
	input  logic signed [slt_pkg::KEY_W-1:0]    key,
	input  logic [slt_pkg::VAL_W-1:0]           record_id,
	input  logic signed [slt_pkg::LINK_W-1:0]   new_page_id,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [2:0]                          status,
	output logic [slt_pkg::VAL_W-1:0]           value_out,
	output logic signed [slt_pkg::KEY_W-1:0]    key_out,
	output logic [slt_pkg::CNT_W-1:0]           count_out,
	output logic signed [slt_pkg::LINK_W-1:0]   old_next_link,
	output logic                                last,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [slt_pkg::CNT_W-1:0]           cfg_wr_data
);

	import slt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_CHECK,
		S_SHIFT,
		S_SHWR,
		S_INS_DONE,
		S_SPLIT,
		S_SP_RD,
		S_SP_EM,
		S_MISC
	} state_t;

	state_t state_q;

	// request
	logic [1:0]               kind_q;
	logic signed [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]         rid_q;
	logic signed [LINK_W-1:0] page_q;

	// table state
	logic [CNT_W-1:0]         count_q;
	logic signed [LINK_W-1:0] next_q;
	logic [CNT_W-1:0]         max_q;

	// sequencer
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [ADDR_W-1:0]        mid_q;
	logic [CNT_W-1:0]         i_q;
	logic [CNT_W-1:0]         end_q;
	logic signed [LINK_W-1:0] old_q;

	// output register
	logic                     out_valid_q;
	status_t                  status_q;
	logic [VAL_W-1:0]         val_out_q;
	logic signed [KEY_W-1:0]  key_out_q;
	logic [CNT_W-1:0]         cnt_out_q;
	logic signed [LINK_W-1:0] link_out_q;
	logic                     last_q;

	// memory port
	logic                     rd_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic [ENTRY_W-1:0]       rd_data;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic [ENTRY_W-1:0]       wr_data;
	logic signed [KEY_W-1:0]  rd_key;
	logic [VAL_W-1:0]         rd_val;

	cmp_t                     cmp;
	logic [CNT_W:0]           mid_sum;
	logic [ADDR_W-1:0]        mid;
	logic                     search_go;
	logic [CNT_W-1:0]         i_dec;
	logic [CNT_W-1:0]         i_inc;
	logic                     shift_more;
	logic                     ins_commit;
	logic                     found;
	logic                     full;
	logic                     out_free;
	logic                     req_xfer;

	// next result
	logic                     ld;
	status_t                  ld_status;
	logic [VAL_W-1:0]         ld_val;
	logic signed [KEY_W-1:0]  ld_key;
	logic signed [LINK_W-1:0] ld_link;
	logic                     ld_last;

	assign rd_key     = rd_data[ENTRY_W-1:VAL_W];
	assign rd_val     = rd_data[VAL_W-1:0];
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[ADDR_W:1];
	assign search_go  = lo_q < hi_q;
	assign i_dec      = i_q - CNT_W'(1);
	assign i_inc      = i_q + CNT_W'(1);
	assign shift_more = i_q > lo_q;
	assign ins_commit = (state_q == S_SHIFT) && !shift_more;
	assign found      = (lo_q < count_q) && cmp.eq;
	assign full       = (count_q >= max_q) || (count_q >= CNT_W'(CAPACITY));
	assign out_free   = !out_valid_q || !rsp_stall;
	assign req_stall  = state_q != S_IDLE;
	assign req_xfer   = req_valid && !req_stall;

	slt_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	slt_keycmp u_cmp (
		.a   (rd_key),
		.b   (key_q),
		.res (cmp)
	);

	// memory access per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_SEARCH: begin
				rd_en   = 1'b1;
				rd_addr = search_go ? mid : lo_q[ADDR_W-1:0];
			end
			S_SHIFT: begin
				if (shift_more) begin
					rd_en   = 1'b1;
					rd_addr = i_dec[ADDR_W-1:0];
				end else begin
					wr_en   = 1'b1;
					wr_addr = lo_q[ADDR_W-1:0];
					wr_data = {key_q, rid_q};
				end
			end
			S_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = i_q[ADDR_W-1:0];
				wr_data = rd_data;
			end
			S_SP_RD: begin
				rd_en   = 1'b1;
				rd_addr = i_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// result to load into the output register
	always_comb begin
		ld        = 1'b0;
		ld_status = ST_OK;
		ld_val    = '0;
		ld_key    = '0;
		ld_link   = '0;
		ld_last   = 1'b1;
		unique case (state_q)
			S_CHECK: begin
				if (kind_q == KIND_LOOKUP) begin
					ld        = out_free;
					ld_status = found ? ST_OK : ST_NOT_FOUND;
					ld_val    = found ? rd_val : '0;
				end else if (found) begin
					ld        = out_free;
					ld_status = ST_DUP;
				end else if (full) begin
					ld        = out_free;
					ld_status = ST_FULL;
				end
			end
			S_INS_DONE, S_MISC: begin
				ld = out_free;
			end
			S_SPLIT: begin
				if (count_q == '0) begin
					ld        = out_free;
					ld_status = ST_EMPTY;
				end
			end
			S_SP_EM: begin
				ld      = out_free;
				ld_val  = rd_val;
				ld_key  = rd_key;
				ld_link = old_q;
				ld_last = i_inc == end_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= '0;
			key_q       <= '0;
			rid_q       <= '0;
			page_q      <= '0;
			count_q     <= '0;
			next_q      <= '1;
			max_q       <= CNT_W'(32);
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			i_q         <= '0;
			end_q       <= '0;
			old_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			val_out_q   <= '0;
			key_out_q   <= '0;
			cnt_out_q   <= '0;
			link_out_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end

			if (ld) begin
				out_valid_q <= 1'b1;
				status_q    <= ld_status;
				val_out_q   <= ld_val;
				key_out_q   <= ld_key;
				cnt_out_q   <= count_q;
				link_out_q  <= ld_link;
				last_q      <= ld_last;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						kind_q <= kind;
						key_q  <= key;
						rid_q  <= record_id;
						page_q <= new_page_id;
						lo_q   <= '0;
						hi_q   <= count_q;
						case (kind)
							KIND_LOOKUP, KIND_INSERT: state_q <= S_SEARCH;
							KIND_SPLIT:               state_q <= S_SPLIT;
							default:                  state_q <= S_MISC;
						endcase
					end
				end
				S_SEARCH: begin
					if (search_go) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CMP: begin
					// lower bound: move past entries below the key
					if (cmp.lt) begin
						lo_q <= CNT_W'(mid_q) + CNT_W'(1);
					end else begin
						hi_q <= CNT_W'(mid_q);
					end
					state_q <= S_SEARCH;
				end
				S_CHECK: begin
					if (kind_q == KIND_LOOKUP || found || full) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						i_q     <= count_q;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (shift_more) begin
						state_q <= S_SHWR;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_INS_DONE;
					end
				end
				S_SHWR: begin
					i_q     <= i_dec;
					state_q <= S_SHIFT;
				end
				S_INS_DONE, S_MISC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SPLIT: begin
					if (count_q == '0) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						// keep the lower half, emit the rest
						count_q <= count_q >> 1;
						i_q     <= count_q >> 1;
						end_q   <= count_q;
						old_q   <= next_q;
						next_q  <= page_q;
						state_q <= S_SP_RD;
					end
				end
				S_SP_RD: begin
					state_q <= S_SP_EM;
				end
				S_SP_EM: begin
					if (out_free) begin
						i_q     <= i_inc;
						state_q <= ld_last ? S_IDLE : S_SP_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid     = out_valid_q;
	assign status        = status_q;
	assign value_out     = val_out_q;
	assign key_out       = key_out_q;
	assign count_out     = cnt_out_q;
	assign old_next_link = link_out_q;
	assign last          = last_q;

	`SLT_ASSERT_IMPLIES(a_count_cap, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SLT_ASSERT_IMPLIES(a_search_bounds, clk, arst_n, state_q == S_SEARCH, (lo_q <= hi_q) && (hi_q <= count_q))
	`SLT_ASSERT_IMPLIES(a_mid_in_range, clk, arst_n, state_q == S_CMP, (CNT_W'(mid_q) >= lo_q) && (CNT_W'(mid_q) < hi_q))
	`SLT_ASSERT_NEXT(a_insert_grows, clk, arst_n, ins_commit, count_q == $past(count_q) + CNT_W'(1))

endmodule

>>> rtl/slt_ram.sv
// Entry memory: one write port, one read port with registered data.
module slt_ram #(
	parameter int DATA_W = 128,
	parameter int DEPTH  = 32,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/slt_keycmp.sv
// Shared signed key comparator used by every search step.
module slt_keycmp (
	input  logic signed [slt_pkg::KEY_W-1:0] a,
	input  logic signed [slt_pkg::KEY_W-1:0] b,
	output slt_pkg::cmp_t                    res
);

	import slt_pkg::*;

	always_comb begin
		res.lt = a < b;
		res.eq = a == b;
	end

endmodule
